// ===== rtl/core/prt_pkg.sv =====
// Package for the pending request tracker: field widths, codes, state and
// command/status types shared by the controller and datapath.
// No dependencies.
package prt_pkg;

  localparam int CAPACITY_DEF = 32;
  localparam int MAX_RESULTS  = 32;
  localparam int HANDLE_W     = 32;
  localparam int OPC_W        = 8;
  localparam int KIND_W       = 3;
  localparam int ID_W         = 64;
  localparam int SEC_W        = 32;
  localparam int TOTAL_W      = 6;
  localparam int FLUSH_W      = $clog2(MAX_RESULTS + 1);

  typedef enum logic [1:0] {
    OP_PUT   = 2'd0,
    OP_GET   = 2'd1,
    OP_TMO   = 2'd2,
    OP_FLUSH = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_NONE = 2'd1,
    ST_FULL = 2'd2,
    ST_BAD  = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    SM_FREE = 2'd0,
    SM_FIND = 2'd1,
    SM_DEC  = 2'd2
  } scan_mode_t;

  typedef enum logic [2:0] {
    S_IDLE     = 3'd0,
    S_CLASSIFY = 3'd1,
    S_SCAN     = 3'd2,
    S_JUDGE    = 3'd3,
    S_REMOVE   = 3'd4,
    S_DEC      = 3'd5,
    S_EMIT     = 3'd6
  } state_t;

  typedef struct packed {
    logic [HANDLE_W-1:0] handle;
    logic [OPC_W-1:0]    op_code;
    logic [KIND_W-1:0]   kind;
    logic [ID_W-1:0]     call_id;
    logic [SEC_W-1:0]    saved_sec;
  } entry_t;

  typedef struct packed {
    logic       latch_req;
    logic       scan_start;
    scan_mode_t scan_mode;
    logic       scan_en;
    logic       do_put;
    logic       do_remove;
    logic       out_load;
    status_t    out_status;
    logic       out_entry;
    logic       out_flush_last;
  } cmd_t;

  typedef struct packed {
    op_t  op;
    logic kind_bad;
    logic scan_done;
    logic found;
    logic expired;
    logic last;
  } sts_t;

endpackage

// ===== rtl/core/prt_in_if.sv =====
// Request channel of the pending request tracker: valid/ready plus one
// request word. Depends on prt_pkg.
interface prt_in_if;
  import prt_pkg::*;
  logic                valid;
  logic                ready;
  logic [1:0]          opcode;
  logic [KIND_W-1:0]   msg_kind;
  logic [ID_W-1:0]     call_id;
  logic [OPC_W-1:0]    op_code;
  logic [HANDLE_W-1:0] handle;
  logic [SEC_W-1:0]    now_sec;

  modport source (output valid, opcode, msg_kind, call_id, op_code, handle, now_sec,
                  input ready);
  modport sink   (input valid, opcode, msg_kind, call_id, op_code, handle, now_sec,
                  output ready);
endinterface

// ===== rtl/core/prt_out_if.sv =====
// Result channel of the pending request tracker: valid/ready plus one
// result word. Depends on prt_pkg.
interface prt_out_if;
  import prt_pkg::*;
  logic                valid;
  logic                ready;
  logic [1:0]          status;
  logic [HANDLE_W-1:0] out_handle;
  logic [OPC_W-1:0]    out_op_code;
  logic [KIND_W-1:0]   out_kind;
  logic [ID_W-1:0]     out_call_id;
  logic                last;
  logic [TOTAL_W-1:0]  pending_total;

  modport source (output valid, status, out_handle, out_op_code, out_kind, out_call_id,
                  last, pending_total, input ready);
  modport sink   (input valid, status, out_handle, out_op_code, out_kind, out_call_id,
                  last, pending_total, output ready);
endinterface

// ===== rtl/core/prt_ctrl.sv =====
// Sequencing state machine of the pending request tracker.
// Drives datapath commands from datapath status. Depends on prt_pkg.
module prt_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  input  prt_pkg::sts_t sts,
  output prt_pkg::cmd_t cmd
);
  import prt_pkg::*;

  state_t state_r, state_nxt;
  logic   remove_ok;

  assign remove_ok = ((sts.op == OP_GET || sts.op == OP_FLUSH) && sts.found) ||
                     (sts.op == OP_TMO && sts.found && sts.expired);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:     if (in_valid) state_nxt = S_CLASSIFY;
      S_CLASSIFY: state_nxt = sts.kind_bad ? S_EMIT : S_SCAN;
      S_SCAN:     if (sts.scan_done) state_nxt = S_JUDGE;
      S_JUDGE: begin
        if (sts.op == OP_PUT || !remove_ok) state_nxt = S_EMIT;
        else state_nxt = S_REMOVE;
      end
      S_REMOVE:   state_nxt = S_DEC;
      S_DEC:      if (sts.scan_done) state_nxt = S_EMIT;
      S_EMIT: begin
        if (out_ready) state_nxt = (sts.op == OP_FLUSH && !sts.last) ? S_REMOVE : S_IDLE;
      end
      default:    state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd            = '0;
    cmd.scan_mode  = SM_FIND;
    cmd.out_status = ST_OK;
    in_ready       = 1'b0;
    out_valid      = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready      = 1'b1;
        cmd.latch_req = in_valid;
      end
      S_CLASSIFY: begin
        if (sts.kind_bad) begin
          cmd.out_load   = 1'b1;
          cmd.out_status = ST_BAD;
        end else begin
          cmd.scan_start = 1'b1;
          cmd.scan_mode  = (sts.op == OP_PUT) ? SM_FREE : SM_FIND;
        end
      end
      S_SCAN: cmd.scan_en = 1'b1;
      S_JUDGE: begin
        if (sts.op == OP_PUT) begin
          cmd.out_load   = 1'b1;
          cmd.do_put     = sts.found;
          cmd.out_status = sts.found ? ST_OK : ST_FULL;
        end else if (!remove_ok) begin
          cmd.out_load   = 1'b1;
          cmd.out_status = ST_NONE;
        end
      end
      S_REMOVE: begin
        cmd.do_remove  = 1'b1;
        cmd.scan_start = 1'b1;
        cmd.scan_mode  = SM_DEC;
      end
      S_DEC: begin
        cmd.scan_en = 1'b1;
        if (sts.scan_done) begin
          cmd.out_load       = 1'b1;
          cmd.out_entry      = 1'b1;
          cmd.out_flush_last = (sts.op == OP_FLUSH);
        end
      end
      S_EMIT: out_valid = 1'b1;
      default: ;
    endcase
  end

endmodule

// ===== rtl/core/prt_dp.sv =====
// Datapath of the pending request tracker: request and config registers,
// entry memories, scan engine, removal and result word. Depends on prt_pkg.
module prt_dp #(
  parameter int CAPACITY = prt_pkg::CAPACITY_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  prt_pkg::cmd_t                  cmd,
  output prt_pkg::sts_t                  sts,
  input  logic                           cfg_we,
  input  logic [prt_pkg::SEC_W-1:0]      cfg_wdata,
  input  logic [1:0]                     opcode,
  input  logic [prt_pkg::KIND_W-1:0]     msg_kind,
  input  logic [prt_pkg::ID_W-1:0]       call_id,
  input  logic [prt_pkg::OPC_W-1:0]      op_code,
  input  logic [prt_pkg::HANDLE_W-1:0]   handle,
  input  logic [prt_pkg::SEC_W-1:0]      now_sec,
  output logic [1:0]                     status,
  output logic [prt_pkg::HANDLE_W-1:0]   out_handle,
  output logic [prt_pkg::OPC_W-1:0]      out_op_code,
  output logic [prt_pkg::KIND_W-1:0]     out_kind,
  output logic [prt_pkg::ID_W-1:0]       out_call_id,
  output logic                           last,
  output logic [prt_pkg::TOTAL_W-1:0]    pending_total
);
  import prt_pkg::*;

  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);

  op_t                 op_r;
  logic [KIND_W-1:0]   kind_r;
  logic [ID_W-1:0]     id_r;
  logic [OPC_W-1:0]    opc_r;
  logic [HANDLE_W-1:0] hnd_r;
  logic [SEC_W-1:0]    now_r;
  logic [SEC_W-1:0]    timeout_r;

  entry_t              ent_mem [CAPACITY];
  logic [IW-1:0]       seq_mem [CAPACITY];

  logic [CAPACITY-1:0] valid_r;
  logic [CW-1:0]       cnt_r, cnt_nxt;
  logic [CW-1:0]       ptr_r;
  logic                rd_vld_r;
  logic [IW-1:0]       rd_idx_r;
  entry_t              rd_ent_r;
  logic [IW-1:0]       rd_seq_r;
  scan_mode_t          mode_r;
  logic                found_r;
  logic [IW-1:0]       best_idx_r;
  entry_t              best_ent_r;
  logic [IW-1:0]       best_seq_r;
  logic [IW-1:0]       rem_seq_r;
  entry_t              rem_ent_r;
  logic [FLUSH_W-1:0]  k_r;
  logic                expired_r;

  status_t             out_status_r;
  entry_t              out_ent_r;
  logic                out_last_r;
  logic [TOTAL_W-1:0]  out_total_r;

  logic                issue, seq_gt, cur_vld, match_free, match_find, take, dec_we;
  logic [IW-1:0]       seq_eff;
  entry_t              put_ent;

  assign issue   = cmd.scan_en && (ptr_r != CW'(CAPACITY));
  assign seq_gt  = rd_seq_r > rem_seq_r;
  assign seq_eff = (mode_r == SM_DEC && seq_gt) ? rd_seq_r - IW'(1) : rd_seq_r;
  assign cur_vld = valid_r[rd_idx_r];

  assign match_free = (mode_r == SM_FREE) && !cur_vld && !found_r;
  assign match_find = (mode_r != SM_FREE) && cur_vld &&
                      (rd_ent_r.kind[2:1] == kind_r[2:1]) &&
                      (mode_r != SM_FIND || op_r != OP_GET || rd_ent_r.call_id == id_r) &&
                      (!found_r || seq_eff < best_seq_r);
  assign take   = rd_vld_r && (match_free || match_find);
  assign dec_we = rd_vld_r && (mode_r == SM_DEC) && cur_vld && seq_gt;

  assign put_ent = '{handle: hnd_r, op_code: opc_r, kind: kind_r, call_id: id_r,
                     saved_sec: now_r};

  always_comb begin
    cnt_nxt = cnt_r;
    if (cmd.do_put) cnt_nxt = cnt_r + CW'(1);
    else if (cmd.do_remove) cnt_nxt = cnt_r - CW'(1);
  end

  always_ff @(posedge clk) begin
    if (cmd.do_put) ent_mem[best_idx_r] <= put_ent;
    if (cmd.do_put) seq_mem[best_idx_r] <= cnt_r[IW-1:0];
    else if (dec_we) seq_mem[rd_idx_r] <= rd_seq_r - IW'(1);
    rd_ent_r <= ent_mem[ptr_r[IW-1:0]];
    rd_seq_r <= seq_mem[ptr_r[IW-1:0]];
    rd_idx_r <= ptr_r[IW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r <= '0;
      valid_r   <= '0;
      cnt_r     <= '0;
      ptr_r     <= '0;
      rd_vld_r  <= 1'b0;
      found_r   <= 1'b0;
      k_r       <= '0;
    end else begin
      if (cfg_we) timeout_r <= cfg_wdata;
      if (cmd.do_put) valid_r[best_idx_r] <= 1'b1;
      else if (cmd.do_remove) valid_r[best_idx_r] <= 1'b0;
      cnt_r <= cnt_nxt;
      if (cmd.scan_start) ptr_r <= '0;
      else if (issue) ptr_r <= ptr_r + CW'(1);
      rd_vld_r <= issue && !cmd.scan_start;
      if (cmd.scan_start) found_r <= 1'b0;
      else if (take) found_r <= 1'b1;
      if (cmd.latch_req) k_r <= '0;
      else if (cmd.do_remove) k_r <= k_r + FLUSH_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_req) begin
      op_r   <= op_t'(opcode);
      kind_r <= msg_kind;
      id_r   <= call_id;
      opc_r  <= op_code;
      hnd_r  <= handle;
      now_r  <= now_sec;
    end
    if (cmd.scan_start) mode_r <= cmd.scan_mode;
    if (take) begin
      best_idx_r <= rd_idx_r;
      best_ent_r <= rd_ent_r;
      best_seq_r <= seq_eff;
    end
    if (cmd.do_remove) begin
      rem_seq_r <= best_seq_r;
      rem_ent_r <= best_ent_r;
    end
    expired_r <= ({1'b0, best_ent_r.saved_sec} + {1'b0, timeout_r}) < {1'b0, now_r};
    if (cmd.out_load) begin
      out_status_r <= cmd.out_status;
      out_ent_r    <= cmd.out_entry ? rem_ent_r : '0;
      out_last_r   <= cmd.out_flush_last ?
                      (!found_r || k_r == FLUSH_W'(MAX_RESULTS)) : 1'b1;
      out_total_r  <= TOTAL_W'(cnt_nxt);
    end
  end

  assign sts.op        = op_r;
  assign sts.kind_bad  = kind_r[2] & kind_r[1];
  assign sts.scan_done = (ptr_r == CW'(CAPACITY)) && !rd_vld_r;
  assign sts.found     = found_r;
  assign sts.expired   = expired_r;
  assign sts.last      = out_last_r;

  assign status        = out_status_r;
  assign out_handle    = out_ent_r.handle;
  assign out_op_code   = out_ent_r.op_code;
  assign out_kind      = out_ent_r.kind;
  assign out_call_id   = out_ent_r.call_id;
  assign last          = out_last_r;
  assign pending_total = out_total_r;

  a_count_matches_valid: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(valid_r) == cnt_r) else $error("entry count out of step with valid bits");

  a_put_needs_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.do_put |-> found_r && !valid_r[best_idx_r]) else $error("put without a free slot");

  a_remove_needs_entry: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.do_remove |-> found_r && valid_r[best_idx_r] && cnt_r != '0)
    else $error("removal of an empty slot");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(CAPACITY)) else $error("entry count above capacity");

endmodule

// ===== rtl/core/pending_request_tracker.sv =====
// Top level of the pending request tracker: controller plus datapath.
// Depends on prt_pkg, prt_in_if, prt_out_if, prt_ctrl and prt_dp.
//
// Usage: requests enter on in_ch (valid/ready), one word per handshake;
// results leave on out_ch (valid/ready). The block handles one request at
// a time; in_ch.ready is high only while it is idle. Every request gives
// one result word, except a flush that removes entries, which gives one word
// per entry removed (up to 32), the final one marked by last.
// Sequence: an invalid kind answers straight after classification; a put or
// a failed get/timeout answers after one scan of the entry memory, one slot
// per cycle through its single read port; a get, timeout or flush that
// removes an entry answers after a second scan, which closes up the arrival
// ranks; each further flush word follows another removal and such a scan.
// timeout_sec is written through cfg_we/cfg_wdata; the user must write it
// only while idle, and the block itself does not enforce this.
// Reset (rst_n low, synchronous) empties the table and clears timeout_sec.
// A stalled receiver holds the result word and the block waits.
module pending_request_tracker #(
  parameter int CAPACITY = prt_pkg::CAPACITY_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  prt_in_if.sink                    in_ch,
  prt_out_if.source                 out_ch,
  input  logic                      cfg_we,
  input  logic [prt_pkg::SEC_W-1:0] cfg_wdata
);
  import prt_pkg::*;

  cmd_t cmd;
  sts_t sts;

  prt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  prt_dp #(.CAPACITY(CAPACITY)) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .sts           (sts),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .opcode        (in_ch.opcode),
    .msg_kind      (in_ch.msg_kind),
    .call_id       (in_ch.call_id),
    .op_code       (in_ch.op_code),
    .handle        (in_ch.handle),
    .now_sec       (in_ch.now_sec),
    .status        (out_ch.status),
    .out_handle    (out_ch.out_handle),
    .out_op_code   (out_ch.out_op_code),
    .out_kind      (out_ch.out_kind),
    .out_call_id   (out_ch.out_call_id),
    .last          (out_ch.last),
    .pending_total (out_ch.pending_total)
  );

endmodule
